// ===== sv/effect_slot_table_assert.svh =====
// Assertion macros used by the effect slot table top level.
`ifndef EFFECT_SLOT_TABLE_ASSERT_SVH
`define EFFECT_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EST_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/est_pkg.sv =====
// Package with the types and constants of the effect slot table.
`default_nettype none
package est_pkg;
    localparam int SLOT_COUNT = 16;
    localparam int MASK_W = 16;
    localparam int MASK_SLOTS = (SLOT_COUNT < MASK_W) ? SLOT_COUNT : MASK_W;
    localparam int TDATA_W = 32;

    typedef enum logic [1:0] {
        SLOT_FREE  = 2'd0,
        SLOT_ALLOC = 2'd1,
        SLOT_PLAY  = 2'd2
    } slot_state_t;

    localparam logic [1:0] OP_CREATE   = 2'd0;
    localparam logic [1:0] OP_SET_TYPE = 2'd1;
    localparam logic [1:0] OP_EFFECT   = 2'd2;

    localparam logic [7:0] EOP_START = 8'd1;
    localparam logic [7:0] EOP_SOLO  = 8'd2;
    localparam logic [7:0] EOP_STOP  = 8'd3;

    localparam logic [7:0] IDX_ALL = 8'hFF;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_BADIDX = 2'd2;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } est_cmd_t;
endpackage
`default_nettype wire

// ===== sv/est_ctrl.sv =====
// Controller state machine that sequences capture, execute and result load.
`default_nettype none
module est_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output est_pkg::est_cmd_t      cmd
);
    import est_pkg::*;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_LOAD
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic ready_reg, ready_next;
    logic out_valid_reg, out_valid_next;

    always_comb begin
        cmd.capture = s_tvalid && ready_reg;
        cmd.exec = (state_reg == CS_EXEC);
        cmd.load = (state_reg == CS_LOAD) && (!out_valid_reg || m_tready);

        state_next = state_reg;
        ready_next = ready_reg;
        case (state_reg)
            CS_IDLE: begin
                if (cmd.capture) begin
                    state_next = CS_EXEC;
                    ready_next = 1'b0;
                end
            end
            CS_EXEC: begin
                state_next = CS_LOAD;
            end
            CS_LOAD: begin
                if (cmd.load) begin
                    state_next = CS_IDLE;
                    ready_next = 1'b1;
                end
            end
            default: begin
                state_next = CS_IDLE;
                ready_next = 1'b1;
            end
        endcase

        if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            ready_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = ready_reg;
    assign m_tvalid = out_valid_reg;
endmodule
`default_nettype wire

// ===== sv/est_datapath.sv =====
// Datapath holding the slot table, the command registers and the result register.
`default_nettype none
module est_datapath (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire est_pkg::est_cmd_t      cmd,
    input  wire logic [1:0]             operation,
    input  wire logic [7:0]             slot_index,
    input  wire logic [7:0]             effect_op,
    input  wire logic [7:0]             effect_type,
    output logic [7:0]                  new_slot,
    output logic [1:0]                  status,
    output logic [est_pkg::MASK_W-1:0]  playing_mask
);
    import est_pkg::*;

    logic [1:0] op_reg;
    logic [7:0] idx_reg;
    logic [7:0] eop_reg;
    logic [7:0] etype_reg;

    slot_state_t slot_state_reg [SLOT_COUNT];
    slot_state_t slot_state_next [SLOT_COUNT];
    logic [7:0] slot_type_reg [SLOT_COUNT];

    logic [7:0] res_slot_reg, res_slot_next;
    logic [1:0] res_status_reg, res_status_next;
    logic [7:0] out_slot_reg;
    logic [1:0] out_status_reg;
    logic [MASK_W-1:0] out_mask_reg;

    logic [SLOT_COUNT-1:0] free_vec;
    logic [SLOT_COUNT-1:0] lowest_free;
    logic [SLOT_COUNT-1:0] sel_vec;
    logic [7:0] first_slot;
    logic any_free;
    logic idx_ok;
    logic [MASK_W-1:0] mask_now;

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            free_vec[i] = (slot_state_reg[i] == SLOT_FREE);
            sel_vec[i] = (idx_reg == 8'(i + 1));
        end
        lowest_free = free_vec & (~free_vec + 1'b1);
        any_free = |free_vec;
        first_slot = 8'd0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (lowest_free[i]) begin
                first_slot = first_slot | 8'(i + 1);
            end
        end
        idx_ok = (idx_reg != 8'd0) && (idx_reg <= 8'(SLOT_COUNT));

        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_state_next[i] = slot_state_reg[i];
            case (op_reg)
                OP_CREATE: begin
                    if (lowest_free[i]) begin
                        slot_state_next[i] = SLOT_ALLOC;
                    end
                end
                OP_EFFECT: begin
                    if (idx_reg == IDX_ALL) begin
                        if (eop_reg == EOP_STOP && slot_state_reg[i] == SLOT_PLAY) begin
                            slot_state_next[i] = SLOT_ALLOC;
                        end
                    end else if (sel_vec[i]) begin
                        if (eop_reg == EOP_START || eop_reg == EOP_SOLO) begin
                            slot_state_next[i] = SLOT_PLAY;
                        end else if (eop_reg == EOP_STOP) begin
                            slot_state_next[i] = SLOT_ALLOC;
                        end
                    end else if (idx_ok && eop_reg == EOP_SOLO
                                 && slot_state_reg[i] == SLOT_PLAY) begin
                        slot_state_next[i] = SLOT_ALLOC;
                    end
                end
                default: begin
                end
            endcase
        end

        res_slot_next = 8'd0;
        res_status_next = STATUS_OK;
        case (op_reg)
            OP_CREATE: begin
                if (any_free) begin
                    res_slot_next = first_slot;
                end else begin
                    res_status_next = STATUS_FULL;
                end
            end
            OP_SET_TYPE: begin
                if (!idx_ok) begin
                    res_status_next = STATUS_BADIDX;
                end
            end
            OP_EFFECT: begin
                if (idx_reg != IDX_ALL && !idx_ok) begin
                    res_status_next = STATUS_BADIDX;
                end
            end
            default: begin
            end
        endcase

        mask_now = '0;
        for (int i = 0; i < MASK_SLOTS; i++) begin
            mask_now[i] = (slot_state_reg[i] == SLOT_PLAY);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg <= operation;
            idx_reg <= slot_index;
            eop_reg <= effect_op;
            etype_reg <= effect_type;
        end
        if (cmd.exec) begin
            res_slot_reg <= res_slot_next;
            res_status_reg <= res_status_next;
        end
        if (cmd.load) begin
            out_slot_reg <= res_slot_reg;
            out_status_reg <= res_status_reg;
            out_mask_reg <= mask_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_state_reg[i] <= SLOT_FREE;
                slot_type_reg[i] <= 8'd0;
            end
        end else if (cmd.exec) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_state_reg[i] <= slot_state_next[i];
                if (op_reg == OP_SET_TYPE && sel_vec[i]) begin
                    slot_type_reg[i] <= etype_reg;
                end
            end
        end
    end

    assign new_slot = out_slot_reg;
    assign status = out_status_reg;
    assign playing_mask = out_mask_reg;
endmodule
`default_nettype wire

// ===== sv/effect_slot_table.sv =====
// Sequencing: each accepted command passes the capture, execute and load steps
// of the controller in order, and no new command is taken until its load; a
// stalled result holds only the load step.
// Reset: synchronous active-low aresetn frees every slot and zeroes all types.
// Top level of the effect slot table.
`default_nettype none
`include "effect_slot_table_assert.svh"
module effect_slot_table (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0: operation[2], slot_index[8], effect_op[8], effect_type[8].
    input  wire logic [est_pkg::TDATA_W-1:0] s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // Fields from bit 0: new_slot[8], status[2], playing_mask[16].
    output logic [est_pkg::TDATA_W-1:0]      m_tdata
);
    import est_pkg::*;

    est_cmd_t cmd;
    logic [7:0] new_slot;
    logic [1:0] status;
    logic [MASK_W-1:0] playing_mask;

    est_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    est_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .operation    (s_tdata[1:0]),
        .slot_index   (s_tdata[9:2]),
        .effect_op    (s_tdata[17:10]),
        .effect_type  (s_tdata[25:18]),
        .new_slot     (new_slot),
        .status       (status),
        .playing_mask (playing_mask)
    );

    assign m_tdata = {6'd0, playing_mask, status, new_slot};

    `EST_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input accepted while a command was in flight")
    `EST_ASSERT_NOW(a_load_no_overwrite, aclk, aresetn, cmd.load, !m_tvalid || m_tready, "result register overwritten before it was taken")
    `EST_ASSERT_NOW(a_status_code, aclk, aresetn, m_tvalid, status == STATUS_OK || status == STATUS_FULL || status == STATUS_BADIDX, "undefined status code")
    `EST_ASSERT_NOW(a_full_no_slot, aclk, aresetn, m_tvalid && status != STATUS_OK, new_slot == 8'd0, "slot reported on a failed command")
endmodule
`default_nettype wire
